[sv/clpm_pkg.sv]
// Package for the callsign longest prefix match block.
// Holds field widths, stream bit positions, the controller state type and the
// command and status structs. No dependencies.
`default_nettype none

package clpm_pkg;

    // Character and field widths
    localparam int CHAR_W    = 8;
    localparam int KEY_CHARS = 6;
    localparam int KEY_W     = CHAR_W * KEY_CHARS;
    localparam int LEN_W     = 3;
    localparam int SLOT_W    = 8;
    localparam int CFG_W     = 9;
    localparam int IDX_OUT_W = 8;

    // Input tdata layout, lowest bit up
    localparam int S_SLOT_LO  = 0;
    localparam int S_KEY_LO   = S_SLOT_LO + SLOT_W;
    localparam int S_KLEN_LO  = S_KEY_LO + KEY_W;
    localparam int S_NAMED_B  = S_KLEN_LO + LEN_W;
    localparam int S_DEST_LO  = S_NAMED_B + 1;
    localparam int S_DLEN_LO  = S_DEST_LO + KEY_W;
    localparam int S_DATA_W   = 112;

    // Output tdata layout, lowest bit up
    localparam int M_FOUND_B  = 0;
    localparam int M_IDX_LO   = 1;
    localparam int M_LEN_LO   = M_IDX_LO + IDX_OUT_W;
    localparam int M_DATA_W   = 16;

    // Stored entry: {named, length, key}
    localparam int ENTRY_W    = KEY_W + LEN_W + 1;

    // Action codes carried in s_tuser
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } clpm_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;       // input transfer this cycle
        logic issue;        // read table entry at scan address, advance
        logic load_result;  // move result into output register
    } clpm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic count_zero;   // no entries in use
        logic last_issue;   // scan address is the last entry in use
        logic out_free;     // output register can take a result this cycle
    } clpm_status_t;

endpackage

`default_nettype wire

[sv/clpm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module clpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata_reg
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/clpm_ctrl.sv]
// Controller state machine for the prefix match block: sequences accept,
// table scan, drain and result hand-off. Depends on clpm_pkg.
`default_nettype none

module clpm_ctrl
    import clpm_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_action,
    output logic              s_tready,
    input  wire clpm_status_t status,
    output clpm_cmd_t         cmd
);

    clpm_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_action == ACT_LOOKUP && !status.count_zero) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (status.last_issue) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        s_tready        = 1'b0;
        cmd.accept      = 1'b0;
        cmd.issue       = 1'b0;
        cmd.load_result = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
            end
            ST_DRAIN: begin
                cmd.issue = 1'b0;
            end
            ST_DONE: begin
                cmd.load_result = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/clpm_dp.sv]
// Datapath for the prefix match block: entry count register, table RAM,
// scan address, prefix compare, best-match tracking and output register.
// Depends on clpm_pkg and clpm_ram.
`default_nettype none

module clpm_dp
    import clpm_pkg::*;
#(
    parameter int ENTRIES = 256
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    input  wire logic [CFG_W-1:0]    cfg_data,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                s_action,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,
    input  wire clpm_cmd_t           cmd,
    output clpm_status_t             status
);

    localparam int AW = $clog2(ENTRIES);

    // Configured entry count
    logic [CFG_W-1:0] entry_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
        end else if (cfg_valid) begin
            entry_count_reg <= cfg_data;
        end
    end

    // Input field split
    logic [SLOT_W-1:0] in_slot;
    logic [KEY_W-1:0]  in_key;
    logic [LEN_W-1:0]  in_klen;
    logic              in_named;
    logic [KEY_W-1:0]  in_dest;
    logic [LEN_W-1:0]  in_dlen;

    assign in_slot  = s_tdata[S_SLOT_LO +: SLOT_W];
    assign in_key   = s_tdata[S_KEY_LO +: KEY_W];
    assign in_klen  = s_tdata[S_KLEN_LO +: LEN_W];
    assign in_named = s_tdata[S_NAMED_B];
    assign in_dest  = s_tdata[S_DEST_LO +: KEY_W];
    assign in_dlen  = s_tdata[S_DLEN_LO +: LEN_W];

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        if (v > LEN_W'(KEY_CHARS)) begin
            return LEN_W'(KEY_CHARS);
        end
        return v;
    endfunction

    // Table write at accept of a write item
    logic [31:0]        slot_wide;
    logic               tbl_we;
    logic [ENTRY_W-1:0] tbl_wdata;

    assign slot_wide = {{(32-SLOT_W){1'b0}}, in_slot};
    assign tbl_we    = cmd.accept && (s_action == ACT_WRITE) && (slot_wide < ENTRIES);
    assign tbl_wdata = {in_named, clamp_len(in_klen), in_key};

    // Effective count, limited to the table depth
    logic [31:0] cnt_wide;
    logic [AW:0] cnt_eff;

    assign cnt_wide = ({{(32-CFG_W){1'b0}}, entry_count_reg} > ENTRIES)
                      ? ENTRIES : {{(32-CFG_W){1'b0}}, entry_count_reg};
    assign cnt_eff  = cnt_wide[AW:0];

    // Lookup operands and scan address
    logic [KEY_W-1:0] dest_reg;
    logic [LEN_W-1:0] dlen_reg;
    logic [AW:0]      count_reg;
    logic [AW-1:0]    addr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            dest_reg  <= in_dest;
            dlen_reg  <= clamp_len(in_dlen);
            count_reg <= cnt_eff;
            addr_reg  <= '0;
        end else if (cmd.issue) begin
            addr_reg <= addr_reg + AW'(1);
        end
    end

    // Table memory
    logic [ENTRY_W-1:0] rdata;

    clpm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .aclk      (aclk),
        .we        (tbl_we),
        .waddr     (slot_wide[AW-1:0]),
        .wdata     (tbl_wdata),
        .re        (cmd.issue),
        .raddr     (addr_reg),
        .rdata_reg (rdata)
    );

    // Read pipeline tag
    logic          rd_valid_reg;
    logic [AW-1:0] rd_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.issue;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= addr_reg;
    end

    // Prefix compare of the entry just read
    logic [KEY_W-1:0] ent_key;
    logic [LEN_W-1:0] ent_len;
    logic             ent_named;
    logic             ent_match;

    assign ent_key   = rdata[KEY_W-1:0];
    assign ent_len   = clamp_len(rdata[KEY_W +: LEN_W]);
    assign ent_named = rdata[ENTRY_W-1];

    always_comb begin
        logic chars_ok;
        chars_ok = 1'b1;
        for (int i = 0; i < KEY_CHARS; i++) begin
            if (LEN_W'(i) < ent_len &&
                ent_key[CHAR_W*(KEY_CHARS-1-i) +: CHAR_W] !=
                dest_reg[CHAR_W*(KEY_CHARS-1-i) +: CHAR_W]) begin
                chars_ok = 1'b0;
            end
        end
        ent_match = chars_ok && (dlen_reg >= ent_len);
    end

    // Best match so far; strict compare keeps the lowest index on ties
    logic             any_reg;
    logic [AW-1:0]    best_idx_reg;
    logic [LEN_W-1:0] best_len_reg;
    logic             best_named_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            any_reg <= 1'b0;
        end else if (cmd.accept) begin
            any_reg <= 1'b0;
        end else if (rd_valid_reg && ent_match && (!any_reg || ent_len > best_len_reg)) begin
            any_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_valid_reg && ent_match && (!any_reg || ent_len > best_len_reg)) begin
            best_idx_reg   <= rd_idx_reg;
            best_len_reg   <= ent_len;
            best_named_reg <= ent_named;
        end
    end

    // Result word
    logic [31:0]         best_idx_wide;
    logic                res_found;
    logic [M_DATA_W-1:0] res_word;

    assign best_idx_wide = {{(32-AW){1'b0}}, best_idx_reg};
    assign res_found     = any_reg && best_named_reg;
    assign res_word      = res_found
        ? {{(M_DATA_W-M_LEN_LO-LEN_W){1'b0}}, best_len_reg,
           best_idx_wide[IDX_OUT_W-1:0], 1'b1}
        : '0;

    // Output register
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_result) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            m_tdata_reg <= res_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Status to controller
    assign status.count_zero = (entry_count_reg == '0);
    assign status.last_issue = (({1'b0, addr_reg} + (AW+1)'(1)) == count_reg);
    assign status.out_free   = !m_tvalid_reg || m_tready;

endmodule

`default_nettype wire

[sv/callsign_longest_prefix_match.sv]
// Top level of the callsign longest prefix match block.
// Joins clpm_ctrl and clpm_dp; depends on clpm_pkg.
//
// The block keeps a table of ENTRIES callsign prefixes in one RAM. An input
// transfer with s_tuser = 0 writes one entry and returns an all-zero
// acknowledge; s_tuser = 1 looks up a destination among the first
// entry_count entries and returns the longest matching entry (lowest index
// on ties), reported as found only if that entry is named, else found = 0.
// A lookup scans N entries, where N is entry_count limited to ENTRIES,
// reading one table entry per cycle through the RAM's single read port.
// A lookup with entry_count 0 skips the scan, like a write. The next item is
// taken once the previous result is in the output register, which may still
// be waiting on m_tready. entry_count is written over the cfg channel, which
// is always ready, and must only change while idle.
`default_nettype none

module callsign_longest_prefix_match
    import clpm_pkg::*;
#(
    parameter int ENTRIES = 256
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Input stream
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // s_tdata: entry_slot[7:0], key_chars[55:8], key_length[58:56],
    //          has_name[59], dest_chars[107:60], dest_length[110:108], pad[111]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // s_tuser: action[0]
    input  wire logic [0:0]          s_tuser,
    // Result stream
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // m_tdata: found[0], match_index[8:1], match_length[11:9], pad[15:12]
    output logic [M_DATA_W-1:0]      m_tdata,
    // Configuration: entry_count
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CFG_W-1:0]    cfg_data
);

    clpm_cmd_t    cmd;
    clpm_status_t status;

    assign cfg_ready = 1'b1;

    clpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_action (s_tuser[0]),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    clpm_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_action  (s_tuser[0]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

[sv/clpm_checker.sv]
// Port-level checker for callsign_longest_prefix_match, with its bind.
// Depends on clpm_pkg.
`default_nettype none

module clpm_checker
    import clpm_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    // A stalled result stays valid
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // One item at a time: no input transfer right after another
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in progress");

    // Not found carries zero index and length
    a_zero_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[M_FOUND_B] |->
            m_tdata[M_IDX_LO +: IDX_OUT_W] == '0 && m_tdata[M_LEN_LO +: LEN_W] == '0)
        else $error("not-found result with nonzero fields");

    // A found result has a key length within range
    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[M_FOUND_B] |-> m_tdata[M_LEN_LO +: LEN_W] <= LEN_W'(KEY_CHARS))
        else $error("match length out of range");

endmodule

bind callsign_longest_prefix_match clpm_checker u_clpm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
